@@ sv/mpct_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and helpers for the mouse packet cursor tracker.
// Used by the channel interfaces, the update unit and the top level.
package mpct_pkg;

  localparam int COORD_W = 12;
  localparam int CFG_W   = 12;

  // Input function codes.
  localparam logic [1:0] FN_DEVICE = 2'd0;
  localparam logic [1:0] FN_SET_X  = 2'd1;
  localparam logic [1:0] FN_SET_Y  = 2'd2;
  localparam logic [1:0] FN_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_PARTIAL   = 3'd0;
  localparam logic [2:0] ST_APPLIED   = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_SYNC_LOST = 3'd3;
  localparam logic [2:0] ST_HOST      = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd1024;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd768;

  // Packet byte phases.
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_XDELTA = 2'd1;
  localparam logic [1:0] PH_YDELTA = 2'd2;

  // Header bit positions.
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_MIDDLE = 2;
  localparam int HDR_ONE    = 3;
  localparam int HDR_XSIGN  = 4;
  localparam int HDR_YSIGN  = 5;
  localparam int HDR_XOVF   = 6;
  localparam int HDR_YOVF   = 7;

  typedef struct packed {
    logic [1:0]         phase;
    logic [7:0]         header;
    logic [7:0]         xbyte;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [2:0]         buttons;
    logic               bad;
  } trk_state_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [COORD_W-1:0] cursor_x;
    logic [COORD_W-1:0] cursor_y;
    logic               left_button;
    logic               right_button;
    logic               middle_button;
    logic               track_bad;
  } trk_result_t;

  // Clamp a signed sum to 0 .. limit.
  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [COORD_W+1:0] v,
                                                     input logic [CFG_W-1:0] limit);
    logic signed [COORD_W+1:0] hi;
    hi = $signed({2'b00, limit});
    if (v < 0) begin
      return '0;
    end else if (v > hi) begin
      return limit;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

@@ sv/mpct_in_if.sv @@
`timescale 1ns / 1ps
// Input channel of the cursor tracker: valid/ready handshake plus item fields.
// Depends on mpct_pkg for field widths.
interface mpct_in_if;
  import mpct_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [7:0]         data_byte;
  logic [COORD_W-1:0] position;

  modport source (output valid, func, data_byte, position, input ready);
  modport sink   (input valid, func, data_byte, position, output ready);
endinterface

@@ sv/mpct_out_if.sv @@
`timescale 1ns / 1ps
// Result channel of the cursor tracker: valid/ready handshake plus result fields.
// Depends on mpct_pkg for field widths.
interface mpct_out_if;
  import mpct_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [COORD_W-1:0] cursor_x;
  logic [COORD_W-1:0] cursor_y;
  logic               left_button;
  logic               right_button;
  logic               middle_button;
  logic               track_bad;

  modport source (output valid, status, cursor_x, cursor_y, left_button, right_button,
                  middle_button, track_bad, input ready);
  modport sink   (input valid, status, cursor_x, cursor_y, left_button, right_button,
                  middle_button, track_bad, output ready);
endinterface

@@ sv/mpct_update.sv @@
`timescale 1ns / 1ps
// Combinational update unit: next tracker state and result for one input beat.
// Depends on mpct_pkg.
module mpct_update
  import mpct_pkg::*;
(
  input  trk_state_t         cur,
  input  logic [1:0]         func,
  input  logic [7:0]         data_byte,
  input  logic [COORD_W-1:0] position,
  input  logic [CFG_W-1:0]   screen_width,
  input  logic [CFG_W-1:0]   screen_height,
  output trk_state_t         nxt,
  output trk_result_t        res
);

  logic signed [COORD_W+1:0] x_sum;
  logic signed [COORD_W+1:0] y_sum;
  logic signed [COORD_W+1:0] x_delta;
  logic signed [COORD_W+1:0] y_delta;

  // Nine-bit deltas, sign from the header, widened for the sum.
  assign x_delta = $signed({{(COORD_W-7){cur.header[HDR_XSIGN]}}, cur.header[HDR_XSIGN],
                            cur.xbyte});
  assign y_delta = $signed({{(COORD_W-7){cur.header[HDR_YSIGN]}}, cur.header[HDR_YSIGN],
                            data_byte});
  assign x_sum = $signed({2'b00, cur.pos_x}) + x_delta;
  assign y_sum = $signed({2'b00, cur.pos_y}) - y_delta;

  logic [2:0] status;

  always_comb begin
    nxt    = cur;
    status = ST_HOST;
    unique case (func)
      FN_DEVICE: begin
        case (cur.phase)
          PH_XDELTA: begin
            nxt.xbyte = data_byte;
            nxt.phase = PH_YDELTA;
            status    = ST_PARTIAL;
          end
          PH_YDELTA: begin
            nxt.phase = PH_HEADER;
            if (cur.header[HDR_YOVF] || cur.header[HDR_XOVF]) begin
              status = ST_OVERFLOW;
            end else if (!cur.header[HDR_ONE]) begin
              nxt.pos_x   = '0;
              nxt.pos_y   = '0;
              nxt.buttons = '0;
              nxt.bad     = 1'b1;
              status      = ST_SYNC_LOST;
            end else begin
              nxt.pos_x   = clamp_coord(x_sum, screen_width);
              nxt.pos_y   = clamp_coord(y_sum, screen_height);
              nxt.buttons = {cur.header[HDR_MIDDLE], cur.header[HDR_RIGHT],
                             cur.header[HDR_LEFT]};
              nxt.bad     = 1'b0;
              status      = ST_APPLIED;
            end
          end
          default: begin
            // The unused fourth phase behaves as the header phase.
            nxt.header = data_byte;
            nxt.phase  = PH_XDELTA;
            status     = ST_PARTIAL;
          end
        endcase
      end
      FN_SET_X: nxt.pos_x = position;
      FN_SET_Y: nxt.pos_y = position;
      FN_CLEAR: begin
        nxt.pos_x   = '0;
        nxt.pos_y   = '0;
        nxt.buttons = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.status        = status;
    res.cursor_x      = nxt.bad ? '0 : nxt.pos_x;
    res.cursor_y      = nxt.bad ? '0 : nxt.pos_y;
    res.left_button   = !nxt.bad && nxt.buttons[0];
    res.right_button  = !nxt.bad && nxt.buttons[1];
    res.middle_button = !nxt.bad && nxt.buttons[2];
    res.track_bad     = nxt.bad;
  end

endmodule

@@ sv/mouse_packet_cursor_tracker_top.sv @@
`timescale 1ns / 1ps
// Top level of the mouse packet cursor tracker: state, configuration and result register.
// Depends on mpct_pkg, mpct_in_if, mpct_out_if and mpct_update.

// Takes one beat per clock cycle while the result sink keeps ready high and returns
// exactly one result beat for each, in the cycle after acceptance. The state update
// and clamp sit between the tracker state registers and a single result register;
// input ready is low only while that register holds an untaken result. Screen limits
// reset to 1024 by 768; the user must write them through the configuration port only
// while the block is idle, which the block itself does not enforce.
module mouse_packet_cursor_tracker_top
  import mpct_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  mpct_in_if.sink          in_ch,
  mpct_out_if.source       out_ch,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] screen_width;
  logic [CFG_W-1:0] screen_height;
  trk_state_t       state;
  trk_state_t       state_next;
  trk_result_t      res_next;
  trk_result_t      result;
  logic             out_valid;
  logic             accept;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  mpct_update u_update (
    .cur           (state),
    .func          (in_ch.func),
    .data_byte     (in_ch.data_byte),
    .position      (in_ch.position),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .nxt           (state_next),
    .res           (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.status        = result.status;
  assign out_ch.cursor_x      = result.cursor_x;
  assign out_ch.cursor_y      = result.cursor_y;
  assign out_ch.left_button   = result.left_button;
  assign out_ch.right_button  = result.right_button;
  assign out_ch.middle_button = result.middle_button;
  assign out_ch.track_bad     = result.track_bad;

  // A bad track always reports a zeroed cursor and released buttons.
  a_bad_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && result.track_bad |->
      result.cursor_x == '0 && result.cursor_y == '0 && !result.left_button &&
      !result.right_button && !result.middle_button)
    else $error("bad track reported a non-zero cursor");

  a_sync_lost_bad : assert property (@(posedge clk) disable iff (rst)
    out_valid && result.status == ST_SYNC_LOST |-> result.track_bad)
    else $error("sync loss without bad flag");

  a_applied_good : assert property (@(posedge clk) disable iff (rst)
    out_valid && result.status == ST_APPLIED |-> !result.track_bad)
    else $error("applied packet left the track bad");

  a_header_phase : assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.func == FN_DEVICE && state.phase == PH_HEADER |=>
      state.phase == PH_XDELTA && state.header == $past(in_ch.data_byte))
    else $error("header byte not captured");

  a_host_keeps_phase : assert property (@(posedge clk) disable iff (rst)
    accept && in_ch.func != FN_DEVICE |=> $stable(state.phase) && $stable(state.bad))
    else $error("host beat disturbed packet phase or bad flag");

endmodule

@@ bench/mouse_packet_cursor_tracker_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the mouse packet cursor tracker: packet, host and clamp cases.
// Depends on mpct_pkg, mpct_in_if, mpct_out_if and mouse_packet_cursor_tracker_top.
module mouse_packet_cursor_tracker_top_tb;
  import mpct_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  // Tracks the cursor as the block should and holds the results still to come.
  class cursor_scoreboard;
    logic [CFG_W-1:0]   width_lim;
    logic [CFG_W-1:0]   height_lim;
    logic [1:0]         phase;
    logic [7:0]         header;
    logic [7:0]         xbyte;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [2:0]         buttons;
    logic               bad;
    trk_result_t        expected_q[$];
    int                 errors;

    function new();
      width_lim  = WIDTH_RESET;
      height_lim = HEIGHT_RESET;
      phase      = PH_HEADER;
      header     = '0;
      xbyte      = '0;
      px         = '0;
      py         = '0;
      buttons    = '0;
      bad        = 1'b0;
      errors     = 0;
    endfunction

    function void set_limit(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_SCREEN_WIDTH) begin
        width_lim = value;
      end else begin
        height_lim = value;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [COORD_W-1:0] clamp_to(int v, logic [CFG_W-1:0] lim);
      if (v < 0) begin
        return '0;
      end
      if (v > int'(lim)) begin
        return lim;
      end
      return v[COORD_W-1:0];
    endfunction

    function void note_input(logic [1:0] fn, logic [7:0] b, logic [COORD_W-1:0] p);
      trk_result_t r;
      logic [2:0]  st;
      int          dx;
      int          dy;
      st = ST_HOST;
      case (fn)
        FN_DEVICE: begin
          case (phase)
            PH_XDELTA: begin
              xbyte = b;
              phase = PH_YDELTA;
              st    = ST_PARTIAL;
            end
            PH_YDELTA: begin
              phase = PH_HEADER;
              if (header[HDR_YOVF] || header[HDR_XOVF]) begin
                st = ST_OVERFLOW;
              end else if (!header[HDR_ONE]) begin
                px      = '0;
                py      = '0;
                buttons = '0;
                bad     = 1'b1;
                st      = ST_SYNC_LOST;
              end else begin
                dx      = header[HDR_XSIGN] ? int'(xbyte) - 256 : int'(xbyte);
                dy      = header[HDR_YSIGN] ? int'(b) - 256 : int'(b);
                px      = clamp_to(int'(px) + dx, width_lim);
                py      = clamp_to(int'(py) - dy, height_lim);
                buttons = header[2:0];
                bad     = 1'b0;
                st      = ST_APPLIED;
              end
            end
            default: begin
              // A phase of three would behave as the header phase.
              header = b;
              phase  = PH_XDELTA;
              st     = ST_PARTIAL;
            end
          endcase
        end
        FN_SET_X: px = p;
        FN_SET_Y: py = p;
        default: begin
          px      = '0;
          py      = '0;
          buttons = '0;
        end
      endcase
      r.status        = st;
      r.cursor_x      = bad ? '0 : px;
      r.cursor_y      = bad ? '0 : py;
      r.left_button   = bad ? 1'b0 : buttons[HDR_LEFT];
      r.right_button  = bad ? 1'b0 : buttons[HDR_RIGHT];
      r.middle_button = bad ? 1'b0 : buttons[HDR_MIDDLE];
      r.track_bad     = bad;
      expected_q.push_back(r);
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(trk_result_t got);
      trk_result_t want;
      if (expected_q.size() == 0) begin
        $error("result beat with no expected result waiting");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", int'(want.status), int'(got.status));
      compare_field("cursor_x", int'(want.cursor_x), int'(got.cursor_x));
      compare_field("cursor_y", int'(want.cursor_y), int'(got.cursor_y));
      compare_field("left_button", int'(want.left_button), int'(got.left_button));
      compare_field("right_button", int'(want.right_button), int'(got.right_button));
      compare_field("middle_button", int'(want.middle_button), int'(got.middle_button));
      compare_field("track_bad", int'(want.track_bad), int'(got.track_bad));
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  mpct_in_if  in_ch();
  mpct_out_if out_ch();

  mouse_packet_cursor_tracker_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cursor_scoreboard sb;
  trk_result_t      got_beat;
  int               idle_cycles;
  int               sink_hold;
  int               sink_calm;
  int               send_quiet;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function logic [COORD_W-1:0] pick_position();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    endcase
  endfunction

  // Result side: ready drops for random stretches, with calm spells in between.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (sink_hold > 0) begin
      out_ch.ready <= 1'b0;
      sink_hold    <= sink_hold - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (sink_calm > 0) begin
        sink_calm <= sink_calm - 1;
      end else if ($urandom_range(0, 149) == 0) begin
        sink_calm <= $urandom_range(50, 200);
      end else if ($urandom_range(0, 3) == 0) begin
        sink_hold <= pick_gap();
      end
    end
  end

  // Both channels are sampled at the edge, before any driven value changes.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) begin
        sb.set_limit(cfg_index, cfg_data);
      end
      if (out_ch.valid && out_ch.ready) begin
        got_beat.status        = out_ch.status;
        got_beat.cursor_x      = out_ch.cursor_x;
        got_beat.cursor_y      = out_ch.cursor_y;
        got_beat.left_button   = out_ch.left_button;
        got_beat.right_button  = out_ch.right_button;
        got_beat.middle_button = out_ch.middle_button;
        got_beat.track_bad     = out_ch.track_bad;
        sb.check_result(got_beat);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(in_ch.func, in_ch.data_byte, in_ch.position);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("mouse_packet_cursor_tracker_top_tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic drive_item(logic [1:0] fn, logic [7:0] b, logic [COORD_W-1:0] p);
    int gap;
    gap = 0;
    if (send_quiet > 0) begin
      send_quiet--;
    end else if ($urandom_range(0, 99) == 0) begin
      send_quiet = $urandom_range(30, 100);
    end else if ($urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= fn;
    in_ch.data_byte <= b;
    in_ch.position  <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Holds the sender off until every result has been taken.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_screen(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    wait_idle();
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
  endtask

  task automatic run_random(int n);
    int         sent;
    logic [7:0] hdr;
    int         kind;
    int         slot;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        hdr = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
          7: if (hdr[7:6] == 2'b00) hdr[HDR_XOVF] = 1'b1;
          8, 9: begin
            hdr[7:6]      = 2'b00;
            hdr[HDR_ONE]  = 1'b0;
          end
          default: begin
            hdr[7:6]      = 2'b00;
            hdr[HDR_ONE]  = 1'b1;
          end
        endcase
        // Now and then a host beat lands in the middle of a packet.
        slot = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
        drive_item(FN_DEVICE, hdr, pick_position());
        if (slot == 1) begin
          drive_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)), pick_position());
          sent++;
        end
        drive_item(FN_DEVICE, 8'($urandom_range(0, 255)), pick_position());
        if (slot == 2) begin
          drive_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)), pick_position());
          sent++;
        end
        drive_item(FN_DEVICE, 8'($urandom_range(0, 255)), pick_position());
        sent += 3;
      end else if (kind < 85) begin
        drive_item(2'($urandom_range(1, 3)), 8'($urandom_range(0, 255)), pick_position());
        sent++;
      end else begin
        drive_item(FN_DEVICE, 8'($urandom_range(0, 255)), pick_position());
        sent++;
      end
      if ($urandom_range(0, 49) == 0) begin
        wait_idle();
      end
    end
  endtask

  initial begin
    sb              = new();
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = CFG_SCREEN_WIDTH;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FN_DEVICE;
    in_ch.data_byte = '0;
    in_ch.position  = '0;
    out_ch.ready    = 1'b0;
    idle_cycles     = 0;
    sink_hold       = 0;
    sink_calm       = 0;
    send_quiet      = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset screen size.
    drive_item(FN_CLEAR, 8'h00, 12'd0);
    // Host sets are taken as given, beyond the clamp limit.
    drive_item(FN_SET_X, 8'hFF, 12'hFFF);
    drive_item(FN_SET_Y, 8'h00, 12'hFFF);
    drive_item(FN_DEVICE, 8'h08, 12'd0);
    drive_item(FN_DEVICE, 8'hFF, 12'd0);
    drive_item(FN_DEVICE, 8'h00, 12'd0);
    drive_item(FN_DEVICE, 8'h3F, 12'hFFF);
    drive_item(FN_DEVICE, 8'h00, 12'hFFF);
    drive_item(FN_DEVICE, 8'h00, 12'hFFF);
    drive_item(FN_DEVICE, 8'h18, 12'd0);
    drive_item(FN_DEVICE, 8'h01, 12'd0);
    drive_item(FN_DEVICE, 8'h80, 12'd0);
    // Overflow packets are dropped whole.
    drive_item(FN_DEVICE, 8'h88, 12'd0);
    drive_item(FN_DEVICE, 8'hFF, 12'd0);
    drive_item(FN_DEVICE, 8'hFF, 12'd0);
    drive_item(FN_DEVICE, 8'h4F, 12'd0);
    drive_item(FN_DEVICE, 8'h10, 12'd0);
    drive_item(FN_DEVICE, 8'h20, 12'd0);
    // A clear always-one bit loses sync; host beats leave the bad flag alone.
    drive_item(FN_DEVICE, 8'h00, 12'd0);
    drive_item(FN_DEVICE, 8'h12, 12'd0);
    drive_item(FN_DEVICE, 8'h34, 12'd0);
    drive_item(FN_SET_X, 8'h00, 12'd100);
    drive_item(FN_DEVICE, 8'h0F, 12'd0);
    drive_item(FN_CLEAR, 8'h00, 12'd0);
    drive_item(FN_DEVICE, 8'h05, 12'd0);
    drive_item(FN_DEVICE, 8'hFB, 12'd0);

    run_random(200);
    set_screen('1, '1);
    run_random(250);
    set_screen('0, '0);
    run_random(150);
    set_screen(12'd10, 12'd7);
    run_random(250);
    set_screen(CFG_W'($urandom_range(0, 4095)), CFG_W'($urandom_range(0, 4095)));
    run_random(200);
    set_screen(WIDTH_RESET, HEIGHT_RESET);
    run_random(200);

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("mouse_packet_cursor_tracker_top_tb OK");
    end else begin
      $display("mouse_packet_cursor_tracker_top_tb NOT OK");
    end
    $finish;
  end

endmodule
